@@ rtl/odo_pkg.sv @@
// shared constants, types and tables of the odometry core
package odo_pkg;

	localparam int MUL_AW   = 69;   // serial multiplier: multiplicand and product width
	localparam int MUL_BW   = 32;   // serial multiplier: multiplier width, one bit per cycle
	localparam int DIV_NW   = 69;   // serial divider: dividend and quotient width
	localparam int DIV_DW   = 17;   // serial divider: divisor width
	localparam int CORDIC_W = 34;   // cordic datapath width
	localparam int TRIG_W   = 18;   // signed q15 sine and cosine

	localparam logic [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(652032875);
	localparam logic [MUL_BW-1:0]   TURN_SCALE   = MUL_BW'(683565);
	localparam logic [DIV_DW-1:0]   MS_PER_S     = DIV_DW'(1000);

	typedef enum logic [1:0] {
		CFG_INTERVAL = 2'd0,
		CFG_THRESH   = 2'd1,
		CFG_TRACK    = 2'd2
	} cfg_idx_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/odo_mul.sv @@
// shift-and-add multiplier, one multiplier bit per cycle
module odo_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [odo_pkg::MUL_AW-1:0] a,
	input  logic [odo_pkg::MUL_BW-1:0] b,
	output logic                       done,
	output logic [odo_pkg::MUL_AW-1:0] prod
);
	import odo_pkg::*;

	localparam int CW = $clog2(MUL_BW);

	logic [MUL_AW-1:0] a_q, p_q;
	logic [MUL_BW-1:0] b_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				p_q <= p_q + a_q;
			a_q <= {a_q[MUL_AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

@@ rtl/odo_div.sv @@
// restoring divider, one quotient bit per cycle
module odo_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [odo_pkg::DIV_NW-1:0] num,
	input  logic [odo_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [odo_pkg::DIV_NW-1:0] quo
);
	import odo_pkg::*;

	localparam int CW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] rem_q, d_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [DIV_DW:0]   trial, sub;
	logic              ge;

	assign trial = {rem_q, q_q[DIV_NW-1]};
	assign sub   = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
			q_q   <= {q_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

@@ rtl/odo_cordic.sv @@
// iterative rotation cordic, one micro-rotation per cycle
module odo_cordic #(
	parameter int ITER = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [15:0]                       angle,
	output logic                              done,
	output logic signed [odo_pkg::TRIG_W-1:0] cos_val,
	output logic signed [odo_pkg::TRIG_W-1:0] sin_val
);
	import odo_pkg::*;

	localparam int IW = (ITER > 1) ? $clog2(ITER) : 1;

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [CORDIC_W-1:0] x_sh, y_sh, at, xf, yf, xa, ya;
	logic [TRIG_W-1:0]          xm, ym;
	logic signed [TRIG_W-1:0]   cos_q, sin_q;
	logic [IW-1:0]              it_q;
	logic                       busy_q, fin_q, done_q, flip_q;
	logic                       flip;
	logic [31:0]                a_rot;

	// left half-plane angles get a half turn first, results negated at the end
	assign flip  = angle[15] ^ angle[14];
	assign a_rot = {angle, 16'h0000} + (flip ? 32'h8000_0000 : 32'h0);

	assign x_sh = x_q >>> it_q;
	assign y_sh = y_q >>> it_q;
	assign at   = signed'({{(CORDIC_W-32){1'b0}}, atan_turn(5'(it_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == IW'(ITER - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// divide by 32768 toward zero
	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;
	assign xa = xf[CORDIC_W-1] ? -xf : xf;
	assign ya = yf[CORDIC_W-1] ? -yf : yf;
	assign xm = xa[15 +: TRIG_W];
	assign ym = ya[15 +: TRIG_W];

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= CORDIC_START;
			y_q    <= '0;
			z_q    <= signed'({{(CORDIC_W-32){a_rot[31]}}, a_rot});
		end else if (busy_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + at;
			end
		end else if (fin_q) begin
			cos_q <= xf[CORDIC_W-1] ? -signed'(xm) : signed'(xm);
			sin_q <= yf[CORDIC_W-1] ? -signed'(ym) : signed'(ym);
		end
	end

	assign done    = done_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

@@ rtl/diff_drive_odometry_core.sv @@
// differential-drive odometry core: sequencer, pose registers and stream ports
//
// Each input transaction is either a wheel speed sample (tuser 0) or a pose clear (tuser 1),
// and each one yields exactly one output transaction carrying the pose and a did_update flag.
// A sample advances the pose only when now_ms minus the time of the last update reaches
// update_interval_ms; it then takes one of three paths: straight line, turn on the spot,
// or swing turn about the instantaneous center. Position is in 1/256 mm, heading is a
// 16-bit binary angle. One item is worked on at a time; all arithmetic runs through a
// one-bit-per-cycle multiplier, a one-bit-per-cycle restoring divider and an iterative
// cordic. The sequencer launches each unit on entering its state and moves on at its done.
// A straight move uses three products, a quotient and a sine/cosine pair, a turn on the
// spot two products and a quotient, and a swing turn five products, three quotients and
// two sine/cosine pairs. A clear or a skipped sample goes from decide straight to result.
// A finished result sits in the output register while the next item is taken.
// Configuration writes are always ready and must only be issued while the core is idle.
module diff_drive_odometry_core #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // left_speed[15:0], right_speed[31:16], now_ms[63:32]
	input  logic        s_axis_tuser,  // opcode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // pos_x[31:0], pos_y[63:32], heading[79:64]
	output logic        m_axis_tuser   // did_update
);
	import odo_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_DECIDE  = 18'h00002,
		S_ST_MUL  = 18'h00004,
		S_ST_DIV  = 18'h00008,
		S_ST_TRIG = 18'h00010,
		S_ST_MULX = 18'h00020,
		S_ST_MULY = 18'h00040,
		S_SW_TRG0 = 18'h00080,
		S_TS_MUL1 = 18'h00100,
		S_TS_MUL2 = 18'h00200,
		S_TS_DIV  = 18'h00400,
		S_SW_TRG1 = 18'h00800,
		S_SW_MULA = 18'h01000,
		S_SW_MULX = 18'h02000,
		S_SW_DIVX = 18'h04000,
		S_SW_MULY = 18'h08000,
		S_SW_DIVY = 18'h10000,
		S_RESULT  = 18'h20000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] interval_q;
	logic [14:0] thresh_q;
	logic [9:0]  track_q;

	// item and pose registers
	logic               op_q, did_q, pend_q, swing_q;
	logic signed [16:0] sum_q, diff_q;
	logic [31:0]        now_q, dt_q, last_q;
	logic [31:0]        x_q, y_q;
	logic [15:0]        hd_q;
	logic signed [TRIG_W-1:0] c0_q, s0_q;
	logic [26:0]        wsum_q;

	// output register
	logic        out_valid_q, out_did_q;
	logic [79:0] out_data_q;

	// shared arithmetic units
	logic              mul_start, mul_done, div_start, div_done, trig_start, trig_done;
	logic              mul_sel, div_sel, trig_sel;
	logic [MUL_AW-1:0] mul_a, mul_prod;
	logic [MUL_BW-1:0] mul_b;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den;
	logic signed [TRIG_W-1:0] trig_cos, trig_sin;

	// derived values
	logic [16:0]        asum, adiff;
	logic [9:0]         w_eff;
	logic [31:0]        dt_now;
	logic [TRIG_W-1:0]  cos_abs, sin_abs;
	logic signed [TRIG_W:0] ds, dc;
	logic [TRIG_W:0]    ds_abs, dc_abs;
	logic [15:0]        step;
	logic [31:0]        st_mag, sw_mag;
	logic               s_accept;

	assign asum    = sum_q[16] ? 17'(-sum_q) : 17'(sum_q);
	assign adiff   = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
	assign w_eff   = (track_q == 10'd0) ? 10'd1 : track_q;   // zero track acts as 1 mm
	assign dt_now  = now_q - last_q;                          // wraps with the ms counter
	assign cos_abs = trig_cos[TRIG_W-1] ? TRIG_W'(-trig_cos) : TRIG_W'(trig_cos);
	assign sin_abs = trig_sin[TRIG_W-1] ? TRIG_W'(-trig_sin) : TRIG_W'(trig_sin);
	// swing turn: sine change for x, cosine change (old minus new) for y
	assign ds      = {trig_sin[TRIG_W-1], trig_sin} - {s0_q[TRIG_W-1], s0_q};
	assign dc      = {c0_q[TRIG_W-1], c0_q} - {trig_cos[TRIG_W-1], trig_cos};
	assign ds_abs  = ds[TRIG_W] ? (TRIG_W+1)'(-ds) : (TRIG_W+1)'(ds);
	assign dc_abs  = dc[TRIG_W] ? (TRIG_W+1)'(-dc) : (TRIG_W+1)'(dc);
	// heading step is bits 31:16 of |R-L|*dt*scale/W
	assign step    = div_quo[31:16];
	// straight: |d|*|trig| / 32768; swing: quotient times 128/32768
	assign st_mag  = mul_prod[46:15];
	assign sw_mag  = div_quo[39:8];

	// operand selection for the shared units
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		div_num  = '0;
		div_den  = '0;
		mul_sel  = 1'b0;
		div_sel  = 1'b0;
		trig_sel = 1'b0;
		unique case (state_q)
			S_ST_MUL: begin
				mul_sel = 1'b1;
				mul_a   = MUL_AW'(asum);
				mul_b   = dt_q;
			end
			S_ST_DIV: begin
				div_sel = 1'b1;
				div_num = {mul_prod[DIV_NW-8:0], 7'b0};
				div_den = MS_PER_S;
			end
			S_ST_TRIG, S_SW_TRG0, S_SW_TRG1: begin
				trig_sel = 1'b1;
			end
			S_ST_MULX: begin
				mul_sel = 1'b1;
				mul_a   = div_quo;
				mul_b   = MUL_BW'(cos_abs);
			end
			S_ST_MULY: begin
				mul_sel = 1'b1;
				mul_a   = div_quo;
				mul_b   = MUL_BW'(sin_abs);
			end
			S_TS_MUL1: begin
				mul_sel = 1'b1;
				mul_a   = MUL_AW'(adiff);
				mul_b   = dt_q;
			end
			S_TS_MUL2: begin
				mul_sel = 1'b1;
				mul_a   = mul_prod;
				mul_b   = TURN_SCALE;
			end
			S_TS_DIV: begin
				div_sel = 1'b1;
				div_num = mul_prod;
				div_den = DIV_DW'(w_eff);
			end
			S_SW_MULA: begin
				mul_sel = 1'b1;
				mul_a   = MUL_AW'(w_eff);
				mul_b   = MUL_BW'(asum);
			end
			S_SW_MULX: begin
				mul_sel = 1'b1;
				mul_a   = MUL_AW'(wsum_q);
				mul_b   = MUL_BW'(ds_abs);
			end
			S_SW_MULY: begin
				mul_sel = 1'b1;
				mul_a   = MUL_AW'(wsum_q);
				mul_b   = MUL_BW'(dc_abs);
			end
			S_SW_DIVX, S_SW_DIVY: begin
				div_sel = 1'b1;
				div_num = mul_prod;
				div_den = adiff;
			end
			default: ;
		endcase
	end

	// a unit is launched once, on the first cycle of its state
	assign mul_start  = pend_q & mul_sel;
	assign div_start  = pend_q & div_sel;
	assign trig_start = pend_q & trig_sel;

	assign s_accept = s_axis_tvalid & s_axis_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 16'd20;
			thresh_q   <= 15'd5;
			track_q    <= 10'd142;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_THRESH:   thresh_q   <= cfg_data[14:0];
				CFG_TRACK:    track_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			hd_q        <= '0;
			last_q      <= '0;
			did_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == S_RESULT && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_accept)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					pend_q <= 1'b1;
					if (op_q) begin
						// pose clear keeps the time of the last update
						did_q   <= 1'b0;
						x_q     <= '0;
						y_q     <= '0;
						hd_q    <= '0;
						state_q <= S_RESULT;
					end else if (dt_now < 32'(interval_q)) begin
						did_q   <= 1'b0;
						state_q <= S_RESULT;
					end else begin
						did_q  <= 1'b1;
						last_q <= now_q;
						if (adiff <= 17'(thresh_q))
							state_q <= S_ST_MUL;
						else if (asum <= 17'(thresh_q))
							state_q <= S_TS_MUL1;
						else
							state_q <= S_SW_TRG0;
					end
				end
				S_ST_MUL, S_TS_MUL1, S_TS_MUL2, S_SW_MULA, S_SW_MULX, S_SW_MULY,
				S_ST_MULX, S_ST_MULY: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (mul_done) begin
						pend_q <= 1'b1;
						unique case (state_q)
							S_ST_MUL:  state_q <= S_ST_DIV;
							S_TS_MUL1: state_q <= S_TS_MUL2;
							S_TS_MUL2: state_q <= S_TS_DIV;
							S_SW_MULA: state_q <= S_SW_MULX;
							S_SW_MULX: state_q <= S_SW_DIVX;
							S_SW_MULY: state_q <= S_SW_DIVY;
							S_ST_MULX: begin
								x_q     <= x_q + ((sum_q[16] ^ trig_cos[TRIG_W-1]) ? -st_mag
									: st_mag);
								state_q <= S_ST_MULY;
							end
							default: begin
								y_q     <= y_q + ((sum_q[16] ^ trig_sin[TRIG_W-1]) ? -st_mag
									: st_mag);
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_ST_DIV, S_TS_DIV, S_SW_DIVX, S_SW_DIVY: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (div_done) begin
						pend_q <= 1'b1;
						unique case (state_q)
							S_ST_DIV: state_q <= S_ST_TRIG;
							S_TS_DIV: begin
								hd_q    <= diff_q[16] ? hd_q - step : hd_q + step;
								state_q <= swing_q ? S_SW_TRG1 : S_RESULT;
							end
							S_SW_DIVX: begin
								x_q     <= x_q + ((sum_q[16] ^ ds[TRIG_W] ^ diff_q[16]) ? -sw_mag
									: sw_mag);
								state_q <= S_SW_MULY;
							end
							default: begin
								y_q     <= y_q + ((sum_q[16] ^ dc[TRIG_W] ^ diff_q[16]) ? -sw_mag
									: sw_mag);
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_ST_TRIG, S_SW_TRG0, S_SW_TRG1: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (trig_done) begin
						pend_q <= 1'b1;
						unique case (state_q)
							S_ST_TRIG: state_q <= S_ST_MULX;
							S_SW_TRG0: state_q <= S_TS_MUL1;
							default:   state_q <= S_SW_MULA;
						endcase
					end
				end
				S_RESULT: begin
					// the output register parts the two sides
					if (!out_valid_q || m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q   <= s_axis_tuser;
			sum_q  <= 17'(signed'(s_axis_tdata[15:0])) + 17'(signed'(s_axis_tdata[31:16]));
			diff_q <= 17'(signed'(s_axis_tdata[31:16])) - 17'(signed'(s_axis_tdata[15:0]));
			now_q  <= s_axis_tdata[63:32];
		end
		if (state_q == S_DECIDE) begin
			dt_q    <= dt_now;
			swing_q <= !(adiff <= 17'(thresh_q)) && !(asum <= 17'(thresh_q));
		end
		if (state_q == S_SW_TRG0 && trig_done) begin
			c0_q <= trig_cos;
			s0_q <= trig_sin;
		end
		if (state_q == S_SW_MULA && mul_done)
			wsum_q <= mul_prod[26:0];
		if (state_q == S_RESULT && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {hd_q, y_q, x_q};
			out_did_q  <= did_q;
		end
	end

	odo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	odo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	odo_cordic #(
		.ITER (TRIG_ITERATIONS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.angle   (hd_q),
		.done    (trig_done),
		.cos_val (trig_cos),
		.sin_val (trig_sin)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_did_q;

endmodule

@@ rtl/odo_checker.sv @@
// port-level checks of the odometry core and their binding
module odo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata
);

	// one item at a time: an accepted transaction closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// the input reopens only together with a result in the output register
	a_reopen_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("input reopened without a result");

	// a new result appears only as the core goes idle
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result shown while still busy");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind diff_drive_odometry_core odo_checker u_odo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
